FILE: hw/rtl/rfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTCM3 frame deframer package
// Shared types, constants and the CRC-24Q byte update.
// ----------------------------------------------------------------------------
package rfd_pkg;

   localparam logic [7:0]  PREAMBLE     = 8'hD3;
   localparam logic [7:0]  HDR_RSV_MASK = 8'hFC;
   localparam logic [7:0]  HDR_LEN_MASK = 8'h03;
   localparam logic [10:0] FRAME_EXTRA  = 11'd6;
   localparam logic [11:0] MTYPE_MASK   = 12'hFFF;
   localparam logic [24:0] CRC24Q_POLY  = 25'h1864CFB;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CRC,
      ST_RESYNC,
      ST_POST,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [10:0] frame_length;
      logic [11:0] message_type;
      logic        crc_ok;
      logic        overrun;
   } report_type;

   // One byte of CRC-24Q, MSB first, no reflection.
   function automatic logic [23:0] crc24q_byte(input logic [23:0] crc,
                                               input logic [7:0]  data);
      logic [24:0] c;
      c = {1'b0, crc ^ {data, 16'h0000}};
      for (int b = 0; b < 8; b++) begin
         c = {c[23:0], 1'b0};
         if (c[24]) begin
            c = c ^ CRC24Q_POLY;
         end
      end
      return c[23:0];
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/rfd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTCM3 deframer channels
// Valid/ready channels for incoming bytes and outgoing frame reports.
// ----------------------------------------------------------------------------
interface rfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface rfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] frame_length;
   logic [11:0] message_type;
   logic        crc_ok;
   logic        overrun;
   logic        last_report;

   modport source (output valid, output frame_length, output message_type,
                   output crc_ok, output overrun, output last_report, input ready);
   modport sink   (input valid, input frame_length, input message_type,
                   input crc_ok, input overrun, input last_report, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rtcm3_frame_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTCM3 frame deframer
// A byte dropped while hunting is only accepted. A stored byte is accepted in IDLE;
// each scan pass then goes through SCAN, reads the header in CRC (none below 3
// bytes), walks the CRC of a whole frame, scans on in RESYNC after a bad header or
// CRC, posts in POST and ends in FINISH, and output stalls hold POST and FINISH.
// Throughput: the input waits until the last pass of the previous byte is done.
// Synchronous reset empties the store and drops any report.
// ----------------------------------------------------------------------------
module rtcm3_frame_deframer #(
   parameter int MAX_FRAME   = 1029,
   parameter int MAX_REPORTS = 64
) (
   input wire logic  clock,
   input wire logic  reset,
   rfd_req_if.sink   req,
   rfd_rsp_if.source rsp
);
   import rfd_pkg::*;

   localparam int AW = $clog2(MAX_FRAME);
   localparam int CW = $clog2(MAX_FRAME + 1);
   localparam int NW = $clog2(MAX_REPORTS + 1);
   localparam int LW = (CW > 11) ? CW : 11;

   function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] head,
                                               input logic [CW-1:0] idx);
      logic [CW:0] sum;
      sum = (CW+1)'(head) + (CW+1)'(idx);
      if (sum >= (CW+1)'(MAX_FRAME)) begin
         sum = sum - (CW+1)'(MAX_FRAME);
      end
      return sum[AW-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] q_idx_ff;
   logic          q_vld_ff, q_vld_in;
   logic [NW-1:0] n_ff, n_in;
   logic [7:0]    b0_ff, b0_in, b1_ff, b1_in;
   logic [23:0]   crc_ff, crc_in, recv_ff, recv_in;
   logic [10:0]   flen_ff, flen_in;
   logic [11:0]   mtype_ff, mtype_in;
   logic          good_ff, good_in, from_rpt_ff, from_rpt_in;
   report_type    pend_ff, pend_in, out_ff, out_in;
   logic          pend_vld_ff, pend_vld_in, out_vld_ff, out_vld_in, out_last_ff, out_last_in;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]    ram_rd_data;

   logic          accept, hunt_drop, out_free;
   logic [CW-1:0] fill_eff;
   logic [10:0]   flen_c;
   logic          hdr_at, hdr_bad, hdr_short, crc_last, good_c, res_hit;
   logic [23:0]   rx_full;
   logic          cap_hit, over_c;

   rfd_ram #(.WIDTH(8), .DEPTH(MAX_FRAME)) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req.data_byte),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign fill_eff  = (fill_ff >= CW'(MAX_FRAME)) ? '0 : fill_ff;
   assign hunt_drop = (fill_eff == '0) && (req.data_byte != PREAMBLE);
   assign out_free  = !out_vld_ff || rsp.ready;

   assign ram_wr_en   = accept && !hunt_drop;
   assign ram_wr_addr = wrap_addr(head_ff, fill_eff);
   assign ram_rd_addr = wrap_addr(head_ff, rd_idx_ff);

   // Header decision is taken when the third byte comes back from the store.
   assign flen_c    = {1'b0, b1_ff[1:0] & HDR_LEN_MASK[1:0], ram_rd_data} + FRAME_EXTRA;
   assign hdr_at    = (state_ff == ST_CRC) && q_vld_ff && (q_idx_ff == CW'(2));
   assign hdr_bad   = (b0_ff != PREAMBLE) || ((b1_ff & HDR_RSV_MASK) != 8'h00) ||
                      (LW'(flen_c) > LW'(MAX_FRAME));
   assign hdr_short = LW'(fill_ff) < LW'(flen_c);
   assign crc_last  = (state_ff == ST_CRC) && q_vld_ff && (q_idx_ff > CW'(2)) &&
                      (LW'(q_idx_ff) == LW'(flen_ff - 11'd1));
   assign rx_full   = {recv_ff[15:0], ram_rd_data};
   assign good_c    = (crc_ff == rx_full);
   assign res_hit   = (state_ff == ST_RESYNC) && q_vld_ff &&
                      ((q_idx_ff == fill_ff) || (ram_rd_data == PREAMBLE));
   assign cap_hit   = (n_ff == NW'(MAX_REPORTS));
   assign over_c    = cap_hit && (fill_ff >= CW'(3));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !hunt_drop) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            state_in = (fill_ff < CW'(3)) ? ST_FINISH : ST_CRC;
         end
         ST_CRC: begin
            if (hdr_at && hdr_bad)        state_in = ST_RESYNC;
            else if (hdr_at && hdr_short) state_in = ST_FINISH;
            else if (crc_last)            state_in = good_c ? ST_POST : ST_RESYNC;
         end
         ST_RESYNC: begin
            if (res_hit) state_in = from_rpt_ff ? ST_POST : ST_SCAN;
         end
         ST_POST: begin
            if (!pend_vld_ff || out_free) state_in = cap_hit ? ST_FINISH : ST_SCAN;
         end
         ST_FINISH: begin
            if (!pend_vld_ff || out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      head_in     = head_ff;
      fill_in     = fill_ff;
      rd_idx_in   = rd_idx_ff;
      n_in        = n_ff;
      b0_in       = b0_ff;
      b1_in       = b1_ff;
      crc_in      = crc_ff;
      recv_in     = recv_ff;
      flen_in     = flen_ff;
      mtype_in    = mtype_ff;
      good_in     = good_ff;
      from_rpt_in = from_rpt_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      out_vld_in  = out_vld_ff && !rsp.ready;
      q_vld_in    = ((state_ff == ST_CRC) || (state_ff == ST_RESYNC)) && (state_in == state_ff);
      if ((state_ff == ST_CRC) || (state_ff == ST_RESYNC)) begin
         rd_idx_in = rd_idx_ff + CW'(1);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fill_in = hunt_drop ? fill_eff : fill_eff + CW'(1);
               n_in    = '0;
            end
         end
         ST_SCAN: begin
            rd_idx_in = '0;
            crc_in    = '0;
         end
         ST_CRC: begin
            if (q_vld_ff) begin
               if (q_idx_ff == CW'(0)) b0_in = ram_rd_data;
               if (q_idx_ff == CW'(1)) b1_in = ram_rd_data;
               if (q_idx_ff <= CW'(2)) begin
                  crc_in   = crc24q_byte(crc_ff, ram_rd_data);
                  flen_in  = flen_c;
                  mtype_in = '0;
               end else if (LW'(q_idx_ff) < LW'(flen_ff - 11'd3)) begin
                  crc_in = crc24q_byte(crc_ff, ram_rd_data);
                  // Message type only exists with two or more payload bytes.
                  if (flen_ff >= 11'd8 && q_idx_ff == CW'(3))
                     mtype_in = {ram_rd_data, mtype_ff[3:0]} & MTYPE_MASK;
                  if (flen_ff >= 11'd8 && q_idx_ff == CW'(4))
                     mtype_in = {mtype_ff[11:4], ram_rd_data[7:4]};
               end else begin
                  recv_in = rx_full;
               end
            end
            if (hdr_at && hdr_bad) begin
               rd_idx_in   = CW'(1);
               from_rpt_in = 1'b0;
            end
            if (crc_last) begin
               n_in    = n_ff + NW'(1);
               good_in = good_c;
               if (good_c) begin
                  head_in = wrap_addr(head_ff, CW'(flen_ff));
                  fill_in = fill_ff - CW'(flen_ff);
               end else begin
                  rd_idx_in   = CW'(1);
                  from_rpt_in = 1'b1;
               end
            end
         end
         ST_RESYNC: begin
            if (res_hit) begin
               head_in = wrap_addr(head_ff, q_idx_ff);
               fill_in = fill_ff - q_idx_ff;
            end
         end
         ST_POST: begin
            if (!pend_vld_ff || out_free) begin
               if (pend_vld_ff) begin
                  out_in      = pend_ff;
                  out_last_in = 1'b0;
                  out_vld_in  = 1'b1;
               end
               pend_in     = '{frame_length: flen_ff, message_type: mtype_ff,
                               crc_ok: good_ff, overrun: over_c};
               pend_vld_in = 1'b1;
               if (over_c) fill_in = '0;
            end
         end
         ST_FINISH: begin
            if (pend_vld_ff && out_free) begin
               out_in      = pend_ff;
               out_last_in = 1'b1;
               out_vld_in  = 1'b1;
               pend_vld_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         fill_ff     <= '0;
         n_ff        <= '0;
         q_vld_ff    <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         fill_ff     <= fill_in;
         n_ff        <= n_in;
         q_vld_ff    <= q_vld_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
      rd_idx_ff   <= rd_idx_in;
      q_idx_ff    <= rd_idx_ff;
      b0_ff       <= b0_in;
      b1_ff       <= b1_in;
      crc_ff      <= crc_in;
      recv_ff     <= recv_in;
      flen_ff     <= flen_in;
      mtype_ff    <= mtype_in;
      good_ff     <= good_in;
      from_rpt_ff <= from_rpt_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid        = out_vld_ff;
   assign rsp.frame_length = out_ff.frame_length;
   assign rsp.message_type = out_ff.message_type;
   assign rsp.crc_ok       = out_ff.crc_ok;
   assign rsp.overrun      = out_ff.overrun;
   assign rsp.last_report  = out_last_ff;

`ifndef NO_ASSERTIONS
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !pend_vld_ff)
      else $error("request accepted while a report is still pending");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(MAX_FRAME))
      else $error("store fill count beyond capacity");
   a_report_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NW'(MAX_REPORTS))
      else $error("report count beyond cap");
   a_overrun_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.overrun |-> rsp.last_report)
      else $error("overrun report is not the final report");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/rfd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1029
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: tb/rfd_tb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTCM3 deframer report checker
// Watches the byte and report channels, predicts the frame reports for each
// accepted byte and compares them in order with the reports that come out.
// ----------------------------------------------------------------------------
module rfd_tb_checker #(
   parameter int MAX_FRAME   = 1029,
   parameter int MAX_REPORTS = 64
) (
   input  logic       clock,
   input  logic       reset,
   rfd_req_if         req,
   rfd_rsp_if         rsp,
   output int         fail_count,
   output int         pending_reports
);
   import rfd_pkg::*;

   typedef struct packed {
      logic [10:0] frame_length;
      logic [11:0] message_type;
      logic        crc_ok;
      logic        overrun;
      logic        last_report;
   } frame_report_type;

   logic [7:0]       byte_buf [MAX_FRAME];
   int               buf_fill;
   frame_report_type report_queue [$];

   assign pending_reports = report_queue.size();

   function automatic logic [23:0] frame_crc(int len);
      logic [24:0] c;
      c = '0;
      for (int i = 0; i < len; i++) begin
         c[23:0] = c[23:0] ^ {byte_buf[i], 16'h0000};
         for (int b = 0; b < 8; b++) begin
            c = {c[23:0], 1'b0};
            if (c[24]) begin
               c = c ^ 25'h1864CFB;
            end
         end
      end
      return c[23:0];
   endfunction

   function automatic void discard_bytes(int count);
      if (count >= buf_fill) begin
         buf_fill = 0;
         return;
      end
      for (int i = 0; i < buf_fill - count; i++) begin
         byte_buf[i] = byte_buf[i + count];
      end
      buf_fill -= count;
   endfunction

   function automatic void skip_to_preamble();
      int nxt;
      nxt = 1;
      while (nxt < buf_fill && byte_buf[nxt] != PREAMBLE) begin
         nxt++;
      end
      discard_bytes(nxt);
   endfunction

   function automatic void predict_reports(logic [7:0] data);
      int               plen;
      int               flen;
      int               n;
      logic [23:0]      rx_crc;
      frame_report_type r;
      frame_report_type made [$];
      n = 0;
      if (buf_fill >= MAX_FRAME) begin
         buf_fill = 0;
      end
      if (buf_fill == 0 && data != PREAMBLE) begin
         return;
      end
      byte_buf[buf_fill] = data;
      buf_fill++;
      while (buf_fill >= 3) begin
         if (byte_buf[0] != PREAMBLE || (byte_buf[1] & HDR_RSV_MASK) != 0) begin
            skip_to_preamble();
            continue;
         end
         plen = {byte_buf[1] & HDR_LEN_MASK, byte_buf[2]};
         flen = plen + 6;
         if (flen > MAX_FRAME) begin
            skip_to_preamble();
            continue;
         end
         if (buf_fill < flen) begin
            break;
         end
         rx_crc = {byte_buf[flen-3], byte_buf[flen-2], byte_buf[flen-1]};
         r.frame_length = flen[10:0];
         r.message_type = (plen >= 2) ? {byte_buf[3], byte_buf[4][7:4]} : 12'd0;
         r.crc_ok = (frame_crc(flen - 3) == rx_crc);
         r.overrun = 1'b0;
         r.last_report = 1'b0;
         n++;
         if (r.crc_ok) begin
            discard_bytes(flen);
         end else begin
            skip_to_preamble();
         end
         if (n >= MAX_REPORTS) begin
            if (buf_fill >= 3) begin
               r.overrun = 1'b1;
               buf_fill = 0;
            end
            made.push_back(r);
            break;
         end
         made.push_back(r);
      end
      if (made.size() > 0) begin
         made[made.size()-1].last_report = 1'b1;
      end
      foreach (made[i]) begin
         report_queue.push_back(made[i]);
      end
   endfunction

   always @(posedge clock) begin
      frame_report_type want;
      if (reset) begin
         buf_fill = 0;
         fail_count <= 0;
      end else begin
         if (req.valid && req.ready) begin
            predict_reports(req.data_byte);
         end
         if (rsp.valid && rsp.ready) begin
            if (report_queue.size() == 0) begin
               $error("unexpected report: length %0d type %0d",
                      rsp.frame_length, rsp.message_type);
               fail_count <= fail_count + 1;
            end else begin
               want = report_queue.pop_front();
               if (rsp.frame_length !== want.frame_length ||
                   rsp.message_type !== want.message_type ||
                   rsp.crc_ok !== want.crc_ok || rsp.overrun !== want.overrun ||
                   rsp.last_report !== want.last_report) begin
                  fail_count <= fail_count + 1;
                  if (rsp.frame_length !== want.frame_length)
                     $error("frame_length: expected %0d actual %0d",
                            want.frame_length, rsp.frame_length);
                  if (rsp.message_type !== want.message_type)
                     $error("message_type: expected %0d actual %0d",
                            want.message_type, rsp.message_type);
                  if (rsp.crc_ok !== want.crc_ok)
                     $error("crc_ok: expected %0b actual %0b", want.crc_ok, rsp.crc_ok);
                  if (rsp.overrun !== want.overrun)
                     $error("overrun: expected %0b actual %0b", want.overrun, rsp.overrun);
                  if (rsp.last_report !== want.last_report)
                     $error("last_report: expected %0b actual %0b",
                            want.last_report, rsp.last_report);
               end
            end
         end
      end
   end
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTCM3 deframer testbench
// Sends directed and random byte streams built mostly from framed messages
// with random payloads and CRC damage, stalls both channels at random, and
// lets the checker judge every frame report.
// ----------------------------------------------------------------------------
module testbench;
   import rfd_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_reports;
   int   idle_cycles;
   bit   long_hold;
   bit   stream_done;
   logic [7:0] byte_stream [$];

   rfd_req_if req ();
   rfd_rsp_if rsp ();

   rtcm3_frame_deframer u_top (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   rfd_tb_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req             (req),
      .rsp             (rsp),
      .fail_count      (fail_count),
      .pending_reports (pending_reports)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [23:0] crc_of(logic [7:0] bytes [$]);
      logic [24:0] c;
      c = '0;
      foreach (bytes[i]) begin
         c[23:0] = c[23:0] ^ {bytes[i], 16'h0000};
         for (int b = 0; b < 8; b++) begin
            c = {c[23:0], 1'b0};
            if (c[24]) begin
               c = c ^ 25'h1864CFB;
            end
         end
      end
      return c[23:0];
   endfunction

   // Appends one frame; a nonzero damage flips bits in the CRC.
   function automatic void add_frame(int plen, logic [23:0] damage, bit zero_fill);
      logic [7:0]  f [$];
      logic [23:0] c;
      f.push_back(PREAMBLE);
      f.push_back({6'd0, plen[9:8]});
      f.push_back(plen[7:0]);
      for (int i = 0; i < plen; i++) begin
         f.push_back(zero_fill ? 8'h00 : 8'($urandom));
      end
      c = crc_of(f) ^ damage;
      f.push_back(c[23:16]);
      f.push_back(c[15:8]);
      f.push_back(c[7:0]);
      foreach (f[i]) byte_stream.push_back(f[i]);
   endfunction

   // Sender.
   initial begin
      int gap;
      req.valid = 1'b0;
      req.data_byte = 8'h00;
      reset = 1'b1;
      stream_done = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: hunting noise, shortest frames, a bad CRC, a bad header
      // and a frame with an all-zero payload.
      byte_stream.push_back(8'h00);
      byte_stream.push_back(8'hFF);
      add_frame(0, 24'd0, 1'b0);
      add_frame(1, 24'd0, 1'b0);
      add_frame(2, 24'h000001, 1'b0);
      byte_stream.push_back(PREAMBLE);
      byte_stream.push_back(8'hFC);
      add_frame(3, 24'd0, 1'b1);
      add_frame(2, 24'd0, 1'b0);
      // Short frames behind a stuck header: the byte that completes it releases all.
      byte_stream.push_back(PREAMBLE);
      byte_stream.push_back(8'h00);
      byte_stream.push_back(8'd40);
      for (int i = 0; i < 7; i++) add_frame(0, 24'd0, 1'b0);
      for (int i = 0; i < 4; i++) byte_stream.push_back(8'($urandom));

      for (int k = 0; k < 15; k++) begin
         case ($urandom_range(0, 5))
            0: byte_stream.push_back(8'($urandom));
            1: add_frame($urandom_range(0, 8), 24'(1 << $urandom_range(0, 23)), 1'b0);
            2: byte_stream.push_back(PREAMBLE);
            default: add_frame($urandom_range(0, 12), 24'd0, 1'b0);
         endcase
      end
      add_frame(1, 24'd0, 1'b0);

      while (byte_stream.size() > 0) begin
         gap = $urandom_range(0, 3);
         if (($urandom_range(0, 3) == 0)) gap = 0;
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req.valid <= 1'b1;
         req.data_byte <= byte_stream.pop_front();
         @(posedge clock);
         while (!req.ready) @(posedge clock);
      end
      req.valid <= 1'b0;
      stream_done = 1'b1;
   end

   // Receiver.
   initial begin
      int gap;
      rsp.ready = 1'b0;
      long_hold = 1'b0;
      @(negedge reset);
      @(posedge clock);
      repeat (400) @(posedge clock);
      long_hold = 1'b1;
      repeat (3000) @(posedge clock);
      long_hold = 1'b0;
      forever begin
         gap = $urandom_range(0, 3);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
      end
   end

   // Watchdog and verdict.
   initial begin
      idle_cycles = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || long_hold) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
         end
         if (stream_done && pending_reports == 0) begin
            break;
         end
      end
      repeat (2200) @(posedge clock);
      if (fail_count == 0 && pending_reports == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule
